// ===== rtl/core/tcw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer package
// Command codes, register indexes, character codes and shared types.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COL_W     = 7;
  localparam int ROW_W     = 6;
  localparam int CHAR_W    = 8;
  localparam int ATTR_W    = 8;
  localparam int CELL_W    = CHAR_W + ATTR_W;
  localparam int CFG_IDX_W = 1;

  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_ERROR     = 8'h45;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

  localparam logic [ATTR_W-1:0] DEFAULT_ATTR_RST = 8'd15;
  localparam logic [ATTR_W-1:0] ERROR_ATTR_RST   = 8'd244;

  typedef enum logic [1:0] {
    CMD_PUT       = 2'd0,
    CMD_BACKSPACE = 2'd1,
    CMD_CLEAR     = 2'd2,
    CMD_READ      = 2'd3
  } tcw_cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEFAULT_ATTR = 1'd0,
    CFG_ERROR_ATTR   = 1'd1
  } tcw_cfg_idx_e;

  typedef struct packed {
    logic [ATTR_W-1:0] default_attr;
    logic [ATTR_W-1:0] error_attr;
  } tcw_cfg_t;

  typedef struct packed {
    logic we;
    logic re;
  } tcw_mem_en_t;

endpackage
`default_nettype wire

// ===== rtl/core/tcw_screen_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Screen memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_screen_ram
  import tcw_pkg::*;
#(
  parameter int AW = 12
) (
  input  wire logic              clk_i,
  input  wire tcw_mem_en_t       mem_en_i,
  input  wire logic [AW-1:0]     waddr_i,
  input  wire logic [CELL_W-1:0] wdata_i,
  input  wire logic [AW-1:0]     raddr_i,
  output logic      [CELL_W-1:0] rdata_o
);

  logic [CELL_W-1:0] mem [(1 << AW)];
  logic [CELL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_en_i.we) begin
      mem[waddr_i] <= wdata_i;
    end
    if (mem_en_i.re) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/core/tcw_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Text console controller
// Command decode, cursor, row copy and fill sweeps over the screen memory.
// ----------------------------------------------------------------------------
module tcw_ctrl
  import tcw_pkg::*;
#(
  parameter int COLS = 80,
  parameter int ROWS = 25,
  localparam int CW = $clog2(COLS),
  localparam int RW = $clog2(ROWS),
  localparam int AW = CW + RW
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tcw_cfg_t          cfg_i,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic [1:0]        command_i,
  input  wire logic [CHAR_W-1:0] char_code_i,
  input  wire logic [ATTR_W-1:0] attribute_i,
  input  wire logic              use_position_i,
  input  wire logic [COL_W-1:0]  column_i,
  input  wire logic [ROW_W-1:0]  row_index_i,
  output logic                   done_o,
  output logic      [COL_W-1:0]  cursor_column_o,
  output logic      [ROW_W-1:0]  cursor_row_o,
  output logic      [CHAR_W-1:0] cell_char_o,
  output logic      [ATTR_W-1:0] cell_attr_o,
  output logic                   scrolled_o,
  output logic                   error_o,
  output tcw_mem_en_t            mem_en_o,
  output logic      [AW-1:0]     mem_waddr_o,
  output logic      [CELL_W-1:0] mem_wdata_o,
  output logic      [AW-1:0]     mem_raddr_o,
  input  wire logic [CELL_W-1:0] mem_rdata_i
);

  localparam int RXW = RW + 1;
  localparam logic [COL_W:0]  COLS_X   = (COL_W + 1)'(COLS);
  localparam logic [ROW_W:0]  ROWS_X   = (ROW_W + 1)'(ROWS);
  localparam logic [CW-1:0]   COL_LAST = CW'(COLS - 1);
  localparam logic [RW-1:0]   ROW_LAST = RW'(ROWS - 1);
  localparam logic [RXW-1:0]  ROWS_RX  = RXW'(ROWS);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_COPY = 4'b0100,
    ST_FILL = 4'b1000
  } tcw_state_e;

  tcw_state_e        state_q, state_d;
  logic [RW-1:0]     sr_q, sr_d;
  logic [CW-1:0]     sc_q, sc_d;
  logic              rd_done_q, rd_done_d;
  logic              wv_q, wv_d;
  logic [AW-1:0]     wa_q, wa_d;
  logic [CELL_W-1:0] fill_q, fill_d;
  logic              pend_q, pend_d;
  logic [CW-1:0]     cur_col_q, cur_col_d;
  logic [RW-1:0]     cur_row_q, cur_row_d;
  logic              done_q, done_d;
  logic [CHAR_W-1:0] char_q, char_d;
  logic [ATTR_W-1:0] attr_q, attr_d;
  logic              scrolled_q, scrolled_d;
  logic              error_q, error_d;

  logic              accept;
  logic              on_screen;
  logic [ATTR_W-1:0] attr_eff;
  logic [CW-1:0]     pcol, ncol, sc_next;
  logic [RW-1:0]     prow, sr_next;
  logic [RXW-1:0]    nrow_x;
  logic              scroll_w;
  logic              sweep_last;
  logic [CW-1:0]     in_col;
  logic [RW-1:0]     in_row;

  assign accept    = start_i && (state_q == ST_IDLE);
  assign busy_o    = (state_q != ST_IDLE);
  assign on_screen = ({1'b0, column_i} < COLS_X) && ({1'b0, row_index_i} < ROWS_X);
  assign attr_eff  = (attribute_i == '0) ? cfg_i.default_attr : attribute_i;
  assign in_col    = column_i[CW-1:0];
  assign in_row    = row_index_i[RW-1:0];
  assign pcol      = use_position_i ? in_col : cur_col_q;
  assign prow      = use_position_i ? in_row : cur_row_q;

  always_comb begin
    ncol   = pcol;
    nrow_x = RXW'(prow);
    if (char_code_i == CH_NEWLINE) begin
      ncol   = '0;
      nrow_x = RXW'(prow) + RXW'(1);
    end else if (char_code_i != CH_BACKSPACE) begin
      if (pcol == COL_LAST) begin
        ncol   = '0;
        nrow_x = RXW'(prow) + RXW'(1);
      end else begin
        ncol = pcol + CW'(1);
      end
    end
  end

  assign scroll_w = (nrow_x == ROWS_RX);

  assign sweep_last = (sr_q == ROW_LAST) && (sc_q == COL_LAST);
  assign sc_next    = (sc_q == COL_LAST) ? '0 : sc_q + CW'(1);
  assign sr_next    = (sc_q == COL_LAST) ? sr_q + RW'(1) : sr_q;

  always_comb begin
    state_d     = state_q;
    sr_d        = sr_q;
    sc_d        = sc_q;
    rd_done_d   = rd_done_q;
    wv_d        = 1'b0;
    wa_d        = wa_q;
    fill_d      = fill_q;
    pend_d      = pend_q;
    cur_col_d   = cur_col_q;
    cur_row_d   = cur_row_q;
    done_d      = 1'b0;
    char_d      = char_q;
    attr_d      = attr_q;
    scrolled_d  = scrolled_q;
    error_d     = error_q;
    mem_en_o    = '0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    mem_raddr_o = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          char_d     = '0;
          attr_d     = '0;
          scrolled_d = 1'b0;
          error_d    = 1'b0;
          unique case (tcw_cmd_e'(command_i))
            CMD_PUT: begin
              if (use_position_i && !on_screen) begin
                mem_en_o.we = 1'b1;
                mem_waddr_o = {ROW_LAST, COL_LAST};
                mem_wdata_o = {cfg_i.error_attr, CH_ERROR};
                error_d     = 1'b1;
                done_d      = 1'b1;
              end else begin
                mem_en_o.we = (char_code_i != CH_NEWLINE);
                mem_waddr_o = {prow, pcol};
                mem_wdata_o = {attr_eff,
                               (char_code_i == CH_BACKSPACE) ? CH_SPACE : char_code_i};
                cur_col_d   = ncol;
                if (scroll_w) begin
                  cur_row_d  = ROW_LAST;
                  scrolled_d = 1'b1;
                  pend_d     = 1'b1;
                  fill_d     = '0;
                  sr_d       = RW'(1);
                  sc_d       = '0;
                  rd_done_d  = 1'b0;
                  state_d    = ST_COPY;
                end else begin
                  cur_row_d = nrow_x[RW-1:0];
                  done_d    = 1'b1;
                end
              end
            end
            CMD_BACKSPACE: begin
              if (cur_col_q != '0) begin
                cur_col_d = cur_col_q - CW'(1);
              end else if (cur_row_q != '0) begin
                cur_col_d = COL_LAST;
                cur_row_d = cur_row_q - RW'(1);
              end
              mem_en_o.we = 1'b1;
              mem_waddr_o = {cur_row_d, cur_col_d};
              mem_wdata_o = {cfg_i.default_attr, CH_SPACE};
              done_d      = 1'b1;
            end
            CMD_CLEAR: begin
              cur_col_d = '0;
              cur_row_d = '0;
              fill_d    = {cfg_i.default_attr, CH_SPACE};
              sr_d      = '0;
              sc_d      = '0;
              pend_d    = 1'b1;
              state_d   = ST_FILL;
            end
            CMD_READ: begin
              if (on_screen) begin
                mem_en_o.re = 1'b1;
                mem_raddr_o = {in_row, in_col};
                state_d     = ST_READ;
              end else begin
                error_d = 1'b1;
                done_d  = 1'b1;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        char_d  = mem_rdata_i[CHAR_W-1:0];
        attr_d  = mem_rdata_i[CELL_W-1:CHAR_W];
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_COPY: begin
        mem_en_o.re = !rd_done_q;
        mem_raddr_o = {sr_q, sc_q};
        mem_en_o.we = wv_q;
        mem_waddr_o = wa_q;
        mem_wdata_o = mem_rdata_i;
        wv_d        = !rd_done_q;
        wa_d        = {sr_q - RW'(1), sc_q};
        if (!rd_done_q) begin
          sr_d = sr_next;
          sc_d = sc_next;
          if (sweep_last) begin
            rd_done_d = 1'b1;
          end
        end else if (wv_q) begin
          sr_d    = ROW_LAST;
          sc_d    = '0;
          state_d = ST_FILL;
        end
      end
      ST_FILL: begin
        mem_en_o.we = 1'b1;
        mem_waddr_o = {sr_q, sc_q};
        mem_wdata_o = fill_q;
        if (sweep_last) begin
          done_d  = pend_q;
          pend_d  = 1'b0;
          state_d = ST_IDLE;
        end else begin
          sr_d = sr_next;
          sc_d = sc_next;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_FILL;
      sr_q       <= '0;
      sc_q       <= '0;
      rd_done_q  <= 1'b0;
      wv_q       <= 1'b0;
      wa_q       <= '0;
      fill_q     <= '0;
      pend_q     <= 1'b0;
      cur_col_q  <= '0;
      cur_row_q  <= '0;
      done_q     <= 1'b0;
      scrolled_q <= 1'b0;
      error_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      sr_q       <= sr_d;
      sc_q       <= sc_d;
      rd_done_q  <= rd_done_d;
      wv_q       <= wv_d;
      wa_q       <= wa_d;
      fill_q     <= fill_d;
      pend_q     <= pend_d;
      cur_col_q  <= cur_col_d;
      cur_row_q  <= cur_row_d;
      done_q     <= done_d;
      scrolled_q <= scrolled_d;
      error_q    <= error_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    attr_q <= attr_d;
  end

  assign done_o          = done_q;
  assign cursor_column_o = COL_W'(cur_col_q);
  assign cursor_row_o    = ROW_W'(cur_row_q);
  assign cell_char_o     = char_q;
  assign cell_attr_o     = attr_q;
  assign scrolled_o      = scrolled_q;
  assign error_o         = error_q;

`ifndef SYNTH
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_en_o.we && mem_en_o.re) |-> (mem_waddr_o != mem_raddr_o))
    else $error("read and write of the same cell in one cycle");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (RXW'(cur_row_q) < ROWS_RX) && ((CW + 1)'(cur_col_q) < (CW + 1)'(COLS)))
    else $error("cursor off screen");

  a_scroll_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && scrolled_q) |-> (cur_row_q == ROW_LAST))
    else $error("scroll left cursor off the last row");

  a_clear_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (command_i == CMD_CLEAR)) |=> (state_q == ST_FILL))
    else $error("clear did not start a fill sweep");

  a_pend_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && (state_q == ST_IDLE)) |-> 1'b0)
    else $error("result left pending while idle");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/text_console_writer_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer
// Character-cell console: screen memory of char/attribute pairs plus cursor.
// ----------------------------------------------------------------------------
// A command is taken when start_i is high and busy_o is low; its single result
// appears on the result ports for one cycle with done_o high and must be taken
// then. Put, backspace, off-screen put and off-screen read give their result
// in the cycle after start; an on-screen read first passes through ST_READ for
// the registered read data. A put that runs past the last cell scrolls: the
// screen memory, with one write port, is walked row by row before the result.
// Clear fills every cell. After reset the block is busy while it clears the
// screen memory; register writes are taken then.
// A new command may start in the same cycle that a result is shown.
// ----------------------------------------------------------------------------
module text_console_writer_top
  import tcw_pkg::*;
#(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire logic [1:0]           command_i,
  input  wire logic [CHAR_W-1:0]    char_code_i,
  input  wire logic [ATTR_W-1:0]    attribute_i,
  input  wire logic                 use_position_i,
  input  wire logic [COL_W-1:0]     column_i,
  input  wire logic [ROW_W-1:0]     row_index_i,
  output logic                      done_o,
  output logic      [COL_W-1:0]     cursor_column_o,
  output logic      [ROW_W-1:0]     cursor_row_o,
  output logic      [CHAR_W-1:0]    cell_char_o,
  output logic      [ATTR_W-1:0]    cell_attr_o,
  output logic                      scrolled_o,
  output logic                      error_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [ATTR_W-1:0]    cfg_data_i
);

  localparam int AW = $clog2(COLS) + $clog2(ROWS);

  tcw_cfg_t          cfg_q, cfg_d;
  tcw_mem_en_t       mem_en;
  logic [AW-1:0]     mem_waddr;
  logic [AW-1:0]     mem_raddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [CELL_W-1:0] mem_rdata;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (tcw_cfg_idx_e'(cfg_index_i))
        CFG_DEFAULT_ATTR: cfg_d.default_attr = cfg_data_i;
        CFG_ERROR_ATTR:   cfg_d.error_attr   = cfg_data_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.default_attr <= DEFAULT_ATTR_RST;
      cfg_q.error_attr   <= ERROR_ATTR_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tcw_ctrl #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .command_i       (command_i),
    .char_code_i     (char_code_i),
    .attribute_i     (attribute_i),
    .use_position_i  (use_position_i),
    .column_i        (column_i),
    .row_index_i     (row_index_i),
    .done_o          (done_o),
    .cursor_column_o (cursor_column_o),
    .cursor_row_o    (cursor_row_o),
    .cell_char_o     (cell_char_o),
    .cell_attr_o     (cell_attr_o),
    .scrolled_o      (scrolled_o),
    .error_o         (error_o),
    .mem_en_o        (mem_en),
    .mem_waddr_o     (mem_waddr),
    .mem_wdata_o     (mem_wdata),
    .mem_raddr_o     (mem_raddr),
    .mem_rdata_i     (mem_rdata)
  );

  tcw_screen_ram #(
    .AW (AW)
  ) u_ram (
    .clk_i    (clk_i),
    .mem_en_i (mem_en),
    .waddr_i  (mem_waddr),
    .wdata_i  (mem_wdata),
    .raddr_i  (mem_raddr),
    .rdata_o  (mem_rdata)
  );

endmodule
`default_nettype wire

// ===== bench/text_console_writer_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer testbench
// Drives console commands from a directed table, then from random phases
// under several attribute settings. A model of the screen and cursor in the
// bench predicts each beat on the result ports, unless the directed table gives
// it; every beat is checked field by field.
// ----------------------------------------------------------------------------
module text_console_writer_top_tb;
  import tcw_pkg::*;

  localparam int COLS        = 80;
  localparam int ROWS        = 25;
  localparam int CELLS       = COLS * ROWS;
  localparam int PHASE_ITEMS = 220;
  localparam int NUM_PHASES  = 5;
  localparam int DRAIN_WAIT  = 16;
  localparam int CYCLE_LIMIT = 8_000_000;

  typedef struct packed {
    tcw_cmd_e          cmd;
    logic [CHAR_W-1:0] ch;
    logic [ATTR_W-1:0] attr;
    logic              use_pos;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } console_cmd_t;

  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [CHAR_W-1:0] ch;
    logic [ATTR_W-1:0] attr;
    logic              scrolled;
    logic              err;
  } console_view_t;

  typedef struct {
    console_cmd_t  c;
    bit            typed;
    console_view_t want;
  } script_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start_i = 1'b0;
  logic                 busy_o;
  logic [1:0]           command_i = '0;
  logic [CHAR_W-1:0]    char_code_i = '0;
  logic [ATTR_W-1:0]    attribute_i = '0;
  logic                 use_position_i = 1'b0;
  logic [COL_W-1:0]     column_i = '0;
  logic [ROW_W-1:0]     row_index_i = '0;
  logic                 done_o;
  logic [COL_W-1:0]     cursor_column_o;
  logic [ROW_W-1:0]     cursor_row_o;
  logic [CHAR_W-1:0]    cell_char_o;
  logic [ATTR_W-1:0]    cell_attr_o;
  logic                 scrolled_o;
  logic                 error_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [ATTR_W-1:0]    cfg_data_i = '0;

  logic [CELL_W-1:0] screen_mem [CELLS];
  int unsigned       cursor_pos;
  logic [ATTR_W-1:0] def_attr_q;
  logic [ATTR_W-1:0] err_attr_q;

  console_view_t pending_views [$];
  script_row_t   script_rows [$];
  int            fail_count = 0;
  int            idle_pct = 27;
  longint        cycle_count = 0;

  text_console_writer_top #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .command_i      (command_i),
    .char_code_i    (char_code_i),
    .attribute_i    (attribute_i),
    .use_position_i (use_position_i),
    .column_i       (column_i),
    .row_index_i    (row_index_i),
    .done_o         (done_o),
    .cursor_column_o(cursor_column_o),
    .cursor_row_o   (cursor_row_o),
    .cell_char_o    (cell_char_o),
    .cell_attr_o    (cell_attr_o),
    .scrolled_o     (scrolled_o),
    .error_o        (error_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic console_view_t console_step(console_cmd_t c);
    console_view_t     v;
    int unsigned       pos;
    logic [ATTR_W-1:0] a;
    bit                on_screen;
    v = '0;
    on_screen = (c.col < COLS) && (c.row < ROWS);
    a = (c.attr == '0) ? def_attr_q : c.attr;
    case (c.cmd)
      CMD_PUT: begin
        if (c.use_pos && !on_screen) begin
          screen_mem[CELLS-1] = {err_attr_q, CH_ERROR};
          v.err = 1'b1;
        end else begin
          pos = c.use_pos ? c.row * COLS + c.col : cursor_pos;
          if (c.ch == CH_NEWLINE) begin
            pos = (pos / COLS + 1) * COLS;
          end else if (c.ch == CH_BACKSPACE) begin
            screen_mem[pos] = {a, CH_SPACE};
          end else begin
            screen_mem[pos] = {a, c.ch};
            pos++;
          end
          if (pos >= CELLS) begin
            for (int i = 0; i < CELLS - COLS; i++) screen_mem[i] = screen_mem[i+COLS];
            for (int i = CELLS - COLS; i < CELLS; i++) screen_mem[i] = '0;
            v.scrolled = 1'b1;
            pos -= COLS;
          end
          cursor_pos = pos;
        end
      end
      CMD_BACKSPACE: begin
        pos = (cursor_pos > 0) ? cursor_pos - 1 : 0;
        screen_mem[pos] = {def_attr_q, CH_SPACE};
        cursor_pos = pos;
      end
      CMD_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen_mem[i] = {def_attr_q, CH_SPACE};
        cursor_pos = 0;
      end
      default: begin
        if (on_screen) begin
          {v.attr, v.ch} = screen_mem[c.row * COLS + c.col];
        end else begin
          v.err = 1'b1;
        end
      end
    endcase
    v.col = COL_W'(cursor_pos % COLS);
    v.row = ROW_W'(cursor_pos / COLS);
    return v;
  endfunction

  function automatic void pick_off_screen(output logic [COL_W-1:0] col,
                                          output logic [ROW_W-1:0] row);
    case ($urandom_range(0, 2))
      0: begin
        col = COL_W'($urandom_range(COLS, 127));
        row = ROW_W'($urandom_range(0, 63));
      end
      1: begin
        col = COL_W'($urandom_range(0, 127));
        row = ROW_W'($urandom_range(ROWS, 63));
      end
      default: begin
        col = COL_W'($urandom_range(COLS, 127));
        row = ROW_W'($urandom_range(ROWS, 63));
      end
    endcase
  endfunction

  function automatic console_cmd_t random_command();
    console_cmd_t c;
    int unsigned  sel;
    int unsigned  pos;
    c.ch = CHAR_W'($urandom_range(0, 255));
    c.attr = ($urandom_range(0, 99) < 20) ? '0 : ATTR_W'($urandom_range(0, 255));
    c.use_pos = 1'($urandom_range(0, 1));
    c.col = COL_W'($urandom_range(0, 127));
    c.row = ROW_W'($urandom_range(0, 63));
    sel = $urandom_range(0, 999);
    if (sel < 800) begin
      c.cmd = CMD_PUT;
      c.use_pos = ($urandom_range(0, 99) < 35);
      case ($urandom_range(0, 24))
        0: c.ch = CH_NEWLINE;
        1: c.ch = CH_BACKSPACE;
        default: ;
      endcase
      if (c.use_pos) begin
        sel = $urandom_range(0, 99);
        if (sel < 15) begin
          pick_off_screen(c.col, c.row);
        end else if (sel < 45) begin
          c.col = COL_W'($urandom_range(COLS - 10, COLS - 1));
          c.row = ROW_W'(ROWS - 1);
        end else begin
          c.col = COL_W'($urandom_range(0, COLS - 1));
          c.row = ROW_W'($urandom_range(0, ROWS - 1));
        end
      end
    end else if (sel < 870) begin
      c.cmd = CMD_BACKSPACE;
    end else if (sel < 885) begin
      c.cmd = CMD_CLEAR;
    end else begin
      c.cmd = CMD_READ;
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        pos = (cursor_pos > 0) ? cursor_pos - 1 : 0;
        c.col = COL_W'(pos % COLS);
        c.row = ROW_W'(pos / COLS);
      end else if (sel < 80) begin
        c.col = COL_W'($urandom_range(0, COLS - 1));
        c.row = ROW_W'($urandom_range(0, ROWS - 1));
      end else begin
        pick_off_screen(c.col, c.row);
      end
    end
    return c;
  endfunction

  task automatic add_row(tcw_cmd_e cmd, int ch, int attr, bit use_pos, int col, int row,
                         bit typed, int wcol = 0, int wrow = 0, int wch = 0,
                         int wattr = 0, bit wscr = 0, bit werr = 0);
    script_row_t r;
    r.c = '{cmd, CHAR_W'(ch), ATTR_W'(attr), use_pos, COL_W'(col), ROW_W'(row)};
    r.typed = typed;
    r.want = '{COL_W'(wcol), ROW_W'(wrow), CHAR_W'(wch), ATTR_W'(wattr), wscr, werr};
    script_rows.push_back(r);
  endtask

  task automatic issue_command(console_cmd_t c, bit typed, console_view_t want);
    console_view_t predicted;
    if ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    start_i        <= 1'b1;
    command_i      <= c.cmd;
    char_code_i    <= c.ch;
    attribute_i    <= c.attr;
    use_position_i <= c.use_pos;
    column_i       <= c.col;
    row_index_i    <= c.row;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    predicted = console_step(c);
    pending_views.push_back(typed ? want : predicted);
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_attrs(logic [ATTR_W-1:0] def_val, logic [ATTR_W-1:0] err_val);
    tcw_cfg_idx_e      idx [2];
    logic [ATTR_W-1:0] val [2];
    idx[0] = CFG_DEFAULT_ATTR;
    idx[1] = CFG_ERROR_ATTR;
    val[0] = def_val;
    val[1] = err_val;
    for (int i = 0; i < 2; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= val[i];
      do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
      if (idx[i] == CFG_DEFAULT_ATTR) def_attr_q = val[i];
      else err_attr_q = val[i];
    end
    cfg_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin : result_monitor
    console_view_t got;
    console_view_t want;
    if (rst_ni && done_o) begin
      got = '{cursor_column_o, cursor_row_o, cell_char_o, cell_attr_o, scrolled_o, error_o};
      if (pending_views.size() == 0) begin
        if (fail_count < 10) $display("unexpected result beat at %0t", $realtime);
        fail_count++;
      end else begin
        want = pending_views.pop_front();
        if (got.col !== want.col || got.row !== want.row || got.ch !== want.ch ||
            got.attr !== want.attr || got.scrolled !== want.scrolled ||
            got.err !== want.err) begin
          if (fail_count < 10) begin
            $display("mismatch at %0t: expected col=%0d row=%0d char=%h attr=%h scr=%b err=%b",
                     $realtime, want.col, want.row, want.ch, want.attr, want.scrolled,
                     want.err);
            $display("                 got      col=%0d row=%0d char=%h attr=%h scr=%b err=%b",
                     got.col, got.row, got.ch, got.attr, got.scrolled, got.err);
          end
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    logic [ATTR_W-1:0] def_set [NUM_PHASES];
    logic [ATTR_W-1:0] err_set [NUM_PHASES];
    console_view_t     none;
    for (int i = 0; i < CELLS; i++) screen_mem[i] = '0;
    cursor_pos = 0;
    def_attr_q = DEFAULT_ATTR_RST;
    err_attr_q = ERROR_ATTR_RST;
    none = '0;

    add_row(CMD_READ, 8'h00, 8'h00, 0, 0, 0, 1);
    add_row(CMD_READ, 8'hFF, 8'hFF, 1, COLS - 1, ROWS - 1, 1);
    add_row(CMD_READ, 8'h00, 8'h00, 0, 127, 63, 1, 0, 0, 0, 0, 0, 1);
    add_row(CMD_READ, 8'h00, 8'h00, 0, COLS, 0, 1, 0, 0, 0, 0, 0, 1);
    add_row(CMD_READ, 8'h00, 8'h00, 0, 0, ROWS, 1, 0, 0, 0, 0, 0, 1);
    add_row(CMD_PUT, 8'h41, 8'h00, 0, 0, 0, 1, 1, 0);
    add_row(CMD_READ, 8'h00, 8'h00, 0, 0, 0, 1, 1, 0, 8'h41, DEFAULT_ATTR_RST);
    add_row(CMD_PUT, 8'hFF, 8'hFF, 0, 0, 0, 0);
    add_row(CMD_PUT, 8'h00, 8'h01, 0, 127, 63, 0);
    add_row(CMD_PUT, CH_NEWLINE, 8'h00, 0, 0, 0, 0);
    add_row(CMD_PUT, CH_BACKSPACE, 8'h80, 0, 0, 0, 0);
    add_row(CMD_BACKSPACE, 8'h33, 8'h44, 1, 5, 5, 0);
    add_row(CMD_PUT, 8'h78, 8'h12, 1, 127, 63, 1, COLS - 1, 0, 0, 0, 0, 1);
    add_row(CMD_READ, 8'h00, 8'h00, 0, COLS - 1, ROWS - 1, 1,
            COLS - 1, 0, CH_ERROR, ERROR_ATTR_RST);
    add_row(CMD_PUT, 8'h7A, 8'h55, 1, COLS - 1, ROWS - 1, 1, 0, ROWS - 1, 0, 0, 1, 0);
    add_row(CMD_READ, 8'h00, 8'h00, 0, COLS - 1, ROWS - 2, 0);
    add_row(CMD_PUT, CH_NEWLINE, 8'h09, 1, 5, ROWS - 1, 1, 0, ROWS - 1, 0, 0, 1, 0);
    add_row(CMD_PUT, CH_BACKSPACE, 8'h00, 1, 0, 0, 0);
    add_row(CMD_BACKSPACE, 8'h00, 8'h00, 0, 0, 0, 1);
    add_row(CMD_READ, 8'h00, 8'h00, 0, 0, 0, 0);
    add_row(CMD_CLEAR, 8'hAA, 8'h55, 1, 127, 63, 1);
    add_row(CMD_READ, 8'h00, 8'h00, 0, 40, 12, 1, 0, 0, CH_SPACE, DEFAULT_ATTR_RST);
    add_row(CMD_PUT, 8'h80, 8'h7F, 0, 127, 63, 0);
    add_row(CMD_READ, 8'h00, 8'h00, 0, 0, 0, 0);
    add_row(CMD_PUT, 8'h7F, 8'h00, 1, 0, ROWS - 1, 0);

    def_set = '{8'h00, 8'hFF, ATTR_W'($urandom_range(1, 254)),
                ATTR_W'($urandom_range(0, 255)), DEFAULT_ATTR_RST};
    err_set = '{8'hFF, 8'h00, ATTR_W'($urandom_range(1, 254)),
                ATTR_W'($urandom_range(0, 255)), ERROR_ATTR_RST};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (script_rows[i]) issue_command(script_rows[i].c, script_rows[i].typed,
                                           script_rows[i].want);
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_attrs(def_set[p], err_set[p]);
      idle_pct = (p == 2) ? 0 : 27;
      repeat (PHASE_ITEMS) issue_command(random_command(), 1'b0, none);
      wait_drained();
    end

    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_count == 0 && pending_views.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
